### design/dwm_pkg.sv
// dwm_pkg: shared types and constants for the dynamic wavelet matrix core.
// No dependencies; every other design file refers to it by scoped names.
package dwm_pkg;

    localparam int DEF_VALUE_BITS = 8;
    localparam int DEF_CAPACITY   = 1024;

    localparam int ACT_W   = 3;
    localparam int IDX_W   = 11;
    localparam int VAL_W   = 8;
    localparam int ANS_W   = 11;
    localparam int ST_W    = 2;
    localparam int LEVEL_W = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SET    = 3'd2,
        ACT_ACCESS = 3'd3,
        ACT_RANK   = 3'd4,
        ACT_KTH    = 3'd5,
        ACT_RFREQ  = 3'd6,
        ACT_SELECT = 3'd7
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

endpackage

### design/dwm_if.sv
// dwm_if: request and response channel interfaces (valid/ready plus payload).
// Depends on dwm_pkg for field widths and codes.
interface dwm_req_if;
    logic                          valid;
    logic                          ready;
    dwm_pkg::t_action              action;
    logic [dwm_pkg::IDX_W-1:0]     index;
    logic [dwm_pkg::IDX_W-1:0]     range_left;
    logic [dwm_pkg::IDX_W-1:0]     range_right;
    logic [dwm_pkg::VAL_W-1:0]     value;

    modport source (output valid, action, index, range_left, range_right, value,
                    input ready);
    modport sink   (input valid, action, index, range_left, range_right, value,
                    output ready);
endinterface

interface dwm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dwm_pkg::ANS_W-1:0]     answer;
    dwm_pkg::t_status              status;

    modport source (output valid, answer, status, input ready);
    modport sink   (input valid, answer, status, output ready);
endinterface

### design/dwm_cell.sv
// dwm_cell: one storage cell of the element ring; holds one value and
// takes its neighbor's value whenever the ring rotates. Depends on dwm_pkg
// for the default width.
module dwm_cell #(
    parameter int W = dwm_pkg::DEF_VALUE_BITS
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_d;
        end
    end

    assign o_q = r_val;

endmodule

### design/dynamic_wavelet_matrix_core.sv
// Dynamic wavelet matrix core. The sequence is kept in a ring of CAPACITY
// cells, position p in cell p; every request except an early error and
// k-th smallest makes one full rotation of the ring, with the value of
// position t at the head cell while the rotation counter is t. Insert,
// delete and set edit the sequence on the fly at the ring's tail; access,
// rank, range count and select are counted at the head in the same
// rotation. K-th smallest resolves one bit per rotation, so it takes one
// rotation per level in use (level_count clamped to 1..VALUE_BITS). A
// request rejected by its range checks skips the rotation. One request is in
// flight at a time, and a new one is taken while the last result waits at
// the output register. Writing level_count empties the sequence.
module dynamic_wavelet_matrix_core #(
    parameter int VALUE_BITS = dwm_pkg::DEF_VALUE_BITS,
    parameter int CAPACITY   = dwm_pkg::DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [dwm_pkg::LEVEL_W-1:0] i_cfg_wr_data,
    dwm_req_if.sink                     i_req,
    dwm_rsp_if.source                   o_rsp
);

    localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // ring position
    localparam int CW = $clog2(CAPACITY + 1);                   // element counts
    localparam int EW = (CW > dwm_pkg::IDX_W) ? CW : dwm_pkg::IDX_W;
    localparam int LV = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int LU = $clog2(VALUE_BITS + 1) + 1;             // levels in use
    localparam int AW = dwm_pkg::ANS_W;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state                        r_state;
    logic [dwm_pkg::LEVEL_W-1:0]   r_level;
    logic [CW-1:0]                 r_count;
    logic [PW-1:0]                 r_t;
    dwm_pkg::t_action              r_act;
    logic [EW-1:0]                 r_idx, r_lft, r_rgt, r_k;
    logic [VALUE_BITS-1:0]         r_x, r_ans_v, r_hold;
    logic [CW-1:0]                 r_acc, r_pos;
    logic                          r_found;
    logic [LV-1:0]                 r_lv;
    logic [AW-1:0]                 r_res_ans;
    dwm_pkg::t_status              r_res_st;
    logic                          r_out_valid;
    logic [AW-1:0]                 r_out_ans;
    dwm_pkg::t_status              r_out_st;

    // ring of cells; cell 0 is the head
    logic [VALUE_BITS-1:0] w_q [CAPACITY];
    logic [VALUE_BITS-1:0] w_tail;
    logic                  w_shift;

    assign w_shift = (r_state == S_RUN);

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_ring
        if (gi == CAPACITY - 1) begin : g_tail
            dwm_cell #(.W(VALUE_BITS)) u_cell (
                .i_clk(i_clk), .i_shift(w_shift), .i_d(w_tail), .o_q(w_q[gi]));
        end else begin : g_body
            dwm_cell #(.W(VALUE_BITS)) u_cell (
                .i_clk(i_clk), .i_shift(w_shift), .i_d(w_q[gi+1]), .o_q(w_q[gi]));
        end
    end

    // levels in use, clamped to 1..VALUE_BITS, and the value mask
    logic [LU-1:0]         w_lu;
    logic [VALUE_BITS-1:0] w_mask;
    always_comb begin
        if (r_level == '0) begin
            w_lu = LU'(1);
        end else if (LU'(r_level) > LU'(VALUE_BITS)) begin
            w_lu = LU'(VALUE_BITS);
        end else begin
            w_lu = LU'(r_level);
        end
        for (int i = 0; i < VALUE_BITS; i++) begin
            w_mask[i] = (LU'(i) < w_lu);
        end
    end

    // request fields, widened for the checks
    logic [EW-1:0]         w_in_idx, w_in_lft, w_in_rgt, w_n;
    logic [VALUE_BITS-1:0] w_in_x;
    logic                  w_in_err;
    dwm_pkg::t_status      w_in_st;
    assign w_in_idx = EW'(i_req.index);
    assign w_in_lft = EW'(i_req.range_left);
    assign w_in_rgt = EW'(i_req.range_right);
    assign w_n      = EW'(r_count);
    assign w_in_x   = VALUE_BITS'(i_req.value) & w_mask;

    always_comb begin
        w_in_err = 1'b0;
        w_in_st  = dwm_pkg::ST_RANGE;
        case (i_req.action)
            dwm_pkg::ACT_INSERT: begin
                if (r_count == CW'(CAPACITY)) begin
                    w_in_err = 1'b1;
                    w_in_st  = dwm_pkg::ST_FULL;
                end else begin
                    w_in_err = (w_in_idx > w_n);
                end
            end
            dwm_pkg::ACT_DELETE, dwm_pkg::ACT_SET, dwm_pkg::ACT_ACCESS:
                w_in_err = (w_in_idx >= w_n);
            dwm_pkg::ACT_RANK:
                w_in_err = (w_in_rgt > w_n);
            dwm_pkg::ACT_KTH:
                w_in_err = (w_in_lft > w_in_rgt) || (w_in_rgt > w_n)
                           || (w_in_idx >= (w_in_rgt - w_in_lft));
            dwm_pkg::ACT_RFREQ:
                w_in_err = (w_in_lft > w_in_rgt) || (w_in_rgt > w_n);
            default:
                w_in_err = 1'b0;   // select is decided during the rotation
        endcase
    end

    // per-cycle work at the head of the ring
    logic [VALUE_BITS-1:0] w_head, w_next, n_ans_v;
    logic [EW-1:0]         w_pe;
    logic                  w_in_rng, w_in_seq, w_kth_hit, w_inc, w_sel_hit, n_found;
    logic [CW-1:0]         n_acc, n_pos;
    logic                  w_last;

    assign w_head   = w_q[0];
    assign w_next   = w_q[1];
    assign w_pe     = EW'(r_t);
    assign w_in_rng = (w_pe >= r_lft) && (w_pe < r_rgt);
    assign w_in_seq = (w_pe < w_n);
    assign w_last   = (r_t == PW'(CAPACITY - 1));
    // same prefix above the current level, zero at the level itself
    assign w_kth_hit = ((w_head >> (r_lv + 1)) == (r_ans_v >> (r_lv + 1)))
                       && !w_head[r_lv];
    assign w_sel_hit = (r_act == dwm_pkg::ACT_SELECT) && w_in_seq
                       && (w_head == r_x) && !r_found && (EW'(r_acc) == r_idx);

    always_comb begin
        case (r_act)
            dwm_pkg::ACT_RANK:   w_inc = (w_pe < r_rgt) && (w_head == r_x);
            dwm_pkg::ACT_RFREQ:  w_inc = w_in_rng && (w_head < r_x);
            dwm_pkg::ACT_KTH:    w_inc = w_in_rng && w_kth_hit;
            dwm_pkg::ACT_SELECT: w_inc = w_in_seq && (w_head == r_x);
            default:             w_inc = 1'b0;
        endcase
        n_acc   = r_acc + CW'(w_inc);
        n_found = r_found | w_sel_hit;
        n_pos   = w_sel_hit ? CW'(r_t) : r_pos;
        n_ans_v = r_ans_v;
        if ((r_act == dwm_pkg::ACT_DELETE || r_act == dwm_pkg::ACT_SET
             || r_act == dwm_pkg::ACT_ACCESS) && (w_pe == r_idx)) begin
            n_ans_v = w_head;
        end
    end

    // tail feed: this is where the sequence gets edited
    always_comb begin
        case (r_act)
            dwm_pkg::ACT_INSERT: begin
                if (w_pe < r_idx) begin
                    w_tail = w_head;
                end else if (w_pe == r_idx) begin
                    w_tail = r_x;
                end else begin
                    w_tail = r_hold;     // everything after slips by one
                end
            end
            dwm_pkg::ACT_DELETE: w_tail = (w_pe >= r_idx) ? w_next : w_head;
            dwm_pkg::ACT_SET:    w_tail = (w_pe == r_idx) ? r_x : w_head;
            default:             w_tail = w_head;
        endcase
    end

    // k-th smallest: decide this level's bit at the end of a rotation
    logic                  w_kth_one;
    logic [VALUE_BITS-1:0] w_kth_val;
    logic                  w_kth_end;
    always_comb begin
        w_kth_one = (EW'(n_acc) <= r_k);
        w_kth_val = r_ans_v;
        if (w_kth_one) begin
            w_kth_val[r_lv] = 1'b1;
        end
    end
    assign w_kth_end = w_last && (r_act == dwm_pkg::ACT_KTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= dwm_pkg::LEVEL_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load from FIN, clear once taken
            if (r_state == S_FIN && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_level <= i_cfg_wr_data;
                r_count <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_act     <= i_req.action;
                        r_idx     <= w_in_idx;
                        r_lft     <= w_in_lft;
                        r_rgt     <= w_in_rgt;
                        r_k       <= w_in_idx;
                        r_x       <= w_in_x;
                        r_t       <= '0;
                        r_acc     <= '0;
                        r_pos     <= '0;
                        r_found   <= 1'b0;
                        r_ans_v   <= '0;
                        r_lv      <= LV'(w_lu - LU'(1));
                        r_res_ans <= '0;
                        if (w_in_err) begin
                            r_res_st <= w_in_st;
                            r_state  <= S_FIN;
                        end else begin
                            r_res_st <= dwm_pkg::ST_OK;
                            r_state  <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    r_t     <= w_last ? '0 : r_t + PW'(1);
                    r_hold  <= w_head;
                    r_acc   <= w_kth_end ? '0 : n_acc;
                    r_pos   <= n_pos;
                    r_found <= n_found;
                    r_ans_v <= w_kth_end ? w_kth_val : n_ans_v;
                    if (w_last) begin
                        // k-th smallest keeps rotating until level 0 is done
                        if (r_act != dwm_pkg::ACT_KTH || r_lv == '0) begin
                            r_state <= S_FIN;
                        end
                        case (r_act)
                            dwm_pkg::ACT_INSERT: r_count <= r_count + CW'(1);
                            dwm_pkg::ACT_DELETE: begin
                                r_count   <= r_count - CW'(1);
                                r_res_ans <= AW'(n_ans_v);
                            end
                            dwm_pkg::ACT_SET, dwm_pkg::ACT_ACCESS:
                                r_res_ans <= AW'(n_ans_v);
                            dwm_pkg::ACT_RANK, dwm_pkg::ACT_RFREQ:
                                r_res_ans <= AW'(n_acc);
                            dwm_pkg::ACT_SELECT: begin
                                if (n_found) begin
                                    r_res_ans <= AW'(n_pos);
                                end else begin
                                    r_res_st <= dwm_pkg::ST_MISSING;
                                end
                            end
                            dwm_pkg::ACT_KTH: begin
                                if (w_kth_one) begin
                                    r_k <= r_k - EW'(n_acc);
                                end
                                if (r_lv == '0) begin
                                    r_res_ans <= AW'(w_kth_val);
                                end else begin
                                    r_lv <= r_lv - LV'(1);   // another rotation
                                end
                            end
                            default: r_res_ans <= '0;
                        endcase
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_ans   <= r_res_ans;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.answer = r_out_ans;
    assign o_rsp.status = r_out_st;

endmodule

### tb/tb_dynamic_wavelet_matrix_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for dynamic_wavelet_matrix_core: a sequence-level
// predictor in a scoreboard class, valid/ready drivers with random idling.
// Depends on dwm_pkg, dwm_if and the core itself.
module tb_dynamic_wavelet_matrix_core;

    localparam int CAP = dwm_pkg::DEF_CAPACITY;

    // Predicts results from a plain list of values. The wavelet matrix is
    // only a storage form, so access/rank/kth/select follow from the list.
    class wm_scoreboard;
        bit [7:0]          seq[$];      // current sequence, already masked
        int                levels;      // clamped level count
        logic [10:0]       exp_ans[$];
        dwm_pkg::t_status  exp_st[$];
        int                errors;

        function new();
            levels = 8;
            errors = 0;
        endfunction

        // level_count write: clamp and empty the sequence
        function void configure(bit [3:0] lc);
            levels = (lc < 1) ? 1 : ((lc > 8) ? 8 : lc);
            seq.delete();
        endfunction

        function int pending();
            return exp_ans.size();
        endfunction

        // word accepted at the request port: update state, queue expectation
        function void note(dwm_pkg::t_action act, int idx, int lft, int rgt, bit [7:0] v);
            int               n;
            int               ans;
            int               cnt;
            bit [7:0]         x;
            bit [7:0]         part[$];
            dwm_pkg::t_status st;
            n   = seq.size();
            ans = 0;
            cnt = 0;
            st  = dwm_pkg::ST_OK;
            x   = v & ((9'd1 << levels) - 1);
            case (act)
                dwm_pkg::ACT_INSERT: begin
                    if (n >= CAP) st = dwm_pkg::ST_FULL;
                    else if (idx > n) st = dwm_pkg::ST_RANGE;
                    else seq.insert(idx, x);
                end
                dwm_pkg::ACT_DELETE: begin
                    if (idx >= n) st = dwm_pkg::ST_RANGE;
                    else begin
                        ans = seq[idx];
                        seq.delete(idx);
                    end
                end
                dwm_pkg::ACT_SET: begin
                    if (idx >= n) st = dwm_pkg::ST_RANGE;
                    else begin
                        ans = seq[idx];
                        seq[idx] = x;
                    end
                end
                dwm_pkg::ACT_ACCESS: begin
                    if (idx >= n) st = dwm_pkg::ST_RANGE;
                    else ans = seq[idx];
                end
                dwm_pkg::ACT_RANK: begin
                    if (rgt > n) st = dwm_pkg::ST_RANGE;
                    else for (int i = 0; i < rgt; i++) if (seq[i] == x) ans++;
                end
                dwm_pkg::ACT_KTH: begin
                    if (lft > rgt || rgt > n || idx >= rgt - lft) st = dwm_pkg::ST_RANGE;
                    else begin
                        for (int i = lft; i < rgt; i++) part.push_back(seq[i]);
                        part.sort();
                        ans = part[idx];
                    end
                end
                dwm_pkg::ACT_RFREQ: begin
                    if (lft > rgt || rgt > n) st = dwm_pkg::ST_RANGE;
                    else for (int i = lft; i < rgt; i++) if (seq[i] < x) ans++;
                end
                default: begin
                    st = dwm_pkg::ST_MISSING;
                    for (int i = 0; i < n; i++) begin
                        if (seq[i] == x) begin
                            if (cnt == idx && st != dwm_pkg::ST_OK) begin
                                st  = dwm_pkg::ST_OK;
                                ans = i;
                            end
                            cnt++;
                        end
                    end
                end
            endcase
            if (st != dwm_pkg::ST_OK) ans = 0;
            exp_ans.push_back(ans[10:0]);
            exp_st.push_back(st);
        endfunction

        // word accepted at the response port
        function void check(logic [10:0] ans, dwm_pkg::t_status st);
            logic [10:0]      ea;
            dwm_pkg::t_status es;
            if (exp_ans.size() == 0) begin
                $display("%0t: unexpected response answer=%0d status=%0d", $time, ans, st);
                errors++;
                return;
            end
            ea = exp_ans.pop_front();
            es = exp_st.pop_front();
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (ans !== ea) begin
                $display("%0t: answer expected %0d actual %0d", $time, ea, ans);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           cfg_wr_en;
    logic [3:0]     cfg_wr_data;
    bit             calm;           // set for a stretch with no idling
    wm_scoreboard   sb;

    dwm_req_if req();
    dwm_rsp_if rsp();

    dynamic_wavelet_matrix_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req),
        .o_rsp         (rsp)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Send one request word; random idle cycles precede it.
    task automatic send_word(dwm_pkg::t_action act, int idx, int lft, int rgt, bit [7:0] v);
        while (!calm && $urandom_range(0, 99) < 35) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.action      <= act;
        req.index       <= idx[10:0];
        req.range_left  <= lft[10:0];
        req.range_right <= rgt[10:0];
        req.value       <= v;
        do @(posedge i_clk); while (!req.ready);
        sb.note(act, idx, lft, rgt, v);
    endtask

    // Drain, let the core settle, then write level_count.
    task automatic write_levels(bit [3:0] lc);
        req.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lc;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        sb.configure(lc);
        @(posedge i_clk);
    endtask

    // Mostly well-formed requests against the current sequence, some noise.
    task automatic random_words(int count, int insert_pct);
        int               r;
        int               n;
        int               idx;
        int               lft;
        int               rgt;
        bit [7:0]         v;
        dwm_pkg::t_action act;
        for (int k = 0; k < count; k++) begin
            n = sb.seq.size();
            r = $urandom_range(0, 99);
            if (r < insert_pct) act = dwm_pkg::ACT_INSERT;
            else act = dwm_pkg::t_action'($urandom_range(1, 7));
            v = $urandom_range(0, 255);
            // pick an existing value half the time so rank/select hit
            if (n > 0 && $urandom_range(0, 1))
                v = sb.seq[$urandom_range(0, n - 1)] | (8'($urandom) << sb.levels);
            rgt = $urandom_range(0, n);
            lft = $urandom_range(0, rgt);
            if (act == dwm_pkg::ACT_INSERT) idx = $urandom_range(0, n);
            else if (act == dwm_pkg::ACT_KTH)
                idx = (rgt > lft) ? $urandom_range(0, rgt - lft - 1) : 0;
            else if (act == dwm_pkg::ACT_SELECT) idx = $urandom_range(0, 3);
            else idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
            if ($urandom_range(0, 99) < 12) idx = $urandom_range(0, 2047);
            if ($urandom_range(0, 99) < 8) lft = $urandom_range(0, 2047);
            if ($urandom_range(0, 99) < 8) rgt = $urandom_range(0, 2047);
            send_word(act, idx, lft, rgt, v);
        end
    endtask

    // response side: random back-pressure, check every accepted word
    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1) sb.check(rsp.answer, rsp.status);
            rsp.ready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    initial begin
        sb = new();
        calm            = 1'b0;
        i_rst_n         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        req.valid       <= 1'b0;
        req.action      <= dwm_pkg::ACT_INSERT;
        req.index       <= '0;
        req.range_left  <= '0;
        req.range_right <= '0;
        req.value       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, range and missing-occurrence errors
        send_word(dwm_pkg::ACT_ACCESS, 0, 0, 0, 8'd0);
        send_word(dwm_pkg::ACT_INSERT, 0, 0, 0, 8'd0);
        send_word(dwm_pkg::ACT_INSERT, 1, 0, 0, 8'd255);
        send_word(dwm_pkg::ACT_INSERT, 5, 0, 0, 8'd5);        // past end
        send_word(dwm_pkg::ACT_INSERT, 0, 0, 0, 8'd128);
        send_word(dwm_pkg::ACT_ACCESS, 2, 0, 0, 8'd0);
        send_word(dwm_pkg::ACT_ACCESS, 3, 0, 0, 8'd0);        // past end
        send_word(dwm_pkg::ACT_RANK, 0, 0, 3, 8'd255);
        send_word(dwm_pkg::ACT_RANK, 0, 0, 4, 8'd255);        // past end
        send_word(dwm_pkg::ACT_KTH, 0, 0, 3, 8'd0);
        send_word(dwm_pkg::ACT_KTH, 2, 0, 3, 8'd0);
        send_word(dwm_pkg::ACT_KTH, 3, 0, 3, 8'd0);           // order too large
        send_word(dwm_pkg::ACT_KTH, 0, 2, 1, 8'd0);           // bad range
        send_word(dwm_pkg::ACT_KTH, 0, 1, 1, 8'd0);           // empty range
        send_word(dwm_pkg::ACT_RFREQ, 0, 1, 1, 8'd200);       // empty range answers 0
        send_word(dwm_pkg::ACT_RFREQ, 0, 0, 3, 8'd200);
        send_word(dwm_pkg::ACT_RFREQ, 0, 0, 2047, 8'd200);    // bad range
        send_word(dwm_pkg::ACT_SELECT, 0, 0, 0, 8'd255);
        send_word(dwm_pkg::ACT_SELECT, 1, 0, 0, 8'd255);      // missing occurrence
        send_word(dwm_pkg::ACT_SET, 1, 0, 0, 8'd7);
        send_word(dwm_pkg::ACT_DELETE, 0, 0, 0, 8'd0);
        send_word(dwm_pkg::ACT_DELETE, 5, 0, 0, 8'd0);        // past end
        send_word(dwm_pkg::ACT_ACCESS, 2047, 2047, 2047, 8'd255);

        random_words(60, 40);
        write_levels(4'd1);
        calm = 1'b1;                                 // no idling here
        random_words(60, 40);
        calm = 1'b0;
        write_levels(4'd0);                          // clamps to one level
        random_words(50, 40);
        write_levels(4'd15);                         // clamps to eight
        random_words(60, 40);
        write_levels(4'd3);
        // fill to capacity, then hit the full store
        while (sb.seq.size() < CAP)
            send_word(dwm_pkg::ACT_INSERT, $urandom_range(0, sb.seq.size()), 0, 0,
                      8'($urandom));
        for (int k = 0; k < 4; k++) send_word(dwm_pkg::ACT_INSERT, 0, 0, 0, 8'($urandom));
        random_words(60, 10);
        write_levels(4'd8);
        random_words(40, 40);

        req.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #(64'd600_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### sim.f
design/dwm_pkg.sv
design/dwm_if.sv
design/dwm_cell.sv
design/dynamic_wavelet_matrix_core.sv
tb/tb_dynamic_wavelet_matrix_core.sv
